@@ design/cq_pkg.sv @@
// ----------------------------------------------------------------------------
// cq_pkg: shared definitions for the compacting queue
// Operation, status, cell command and controller state codes, plus defaults.
// ----------------------------------------------------------------------------
package cq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_W           = 5;
  localparam int KIND_W          = 3;
  localparam int STATUS_W        = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [KIND_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_REM    = 3'd2,
    OP_REMDEQ = 3'd3,
    OP_PEEK   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_SHIFT   = 2'd2,
    CELL_COMPACT = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

@@ design/cq_cell.sv @@
// ----------------------------------------------------------------------------
// cq_cell: one queue slot
// Holds one entry, flags a key match and takes its upper neighbor's entry on
// a shift or when a match sits at or below it during compaction.
// ----------------------------------------------------------------------------
module cq_cell #(
  parameter int VALUE_WIDTH = cq_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  cq_pkg::cell_op_t       cell_op,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] element,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] next_data,
  input  logic                   del_in,
  output logic [VALUE_WIDTH-1:0] data,
  output logic                   del_out
);

  logic [VALUE_WIDTH-1:0] data_r;
  logic                   occupied;
  logic                   match;

  assign occupied = CNT_W'(IDX) < count;
  assign match    = occupied && (data_r == key);
  // first match at or below this slot pulls everything above it down
  assign del_out  = del_in | match;
  assign data     = data_r;

  always_ff @(posedge clk) begin
    unique case (cell_op)
      cq_pkg::CELL_HOLD: begin
        data_r <= data_r;
      end
      cq_pkg::CELL_LOAD: begin
        if (CNT_W'(IDX) == count) begin
          data_r <= element;
        end
      end
      cq_pkg::CELL_SHIFT: begin
        data_r <= next_data;
      end
      cq_pkg::CELL_COMPACT: begin
        if (del_out) begin
          data_r <= next_data;
        end
      end
      default: begin
        data_r <= data_r;
      end
    endcase
  end

endmodule

@@ design/compacting_queue_with_removal.sv @@
// ----------------------------------------------------------------------------
// compacting_queue_with_removal: bounded FIFO with delete by value
// A row of slot cells kept packed from the head, with a small controller.
// ----------------------------------------------------------------------------
// Usage: words enter on in_valid/in_stall with in_kind (enqueue, dequeue,
// remove, remove-and-dequeue, peek), in_element and in_match_key. Each word
// yields exactly one result word on out_valid/out_stall carrying out_status,
// out_value_out and out_length (entries held afterwards).
// Enqueue, dequeue and peek complete in the accept cycle; the result is
// registered and shows in the cycle after. Unless the queue is empty, remove
// and remove-and-dequeue scan the cell row: each cycle the lowest matching
// entry is deleted and all cells above it move down one place; the block
// stays busy until a scan step finds no match with the result register free
// (remove-and-dequeue spends its accept cycle popping the head). Throughput
// is one word per cycle for enqueue, dequeue and peek while results are taken.
// A new word is taken only when the controller is idle and the result
// register is empty or being read; while out_stall holds a pending result, it
// stays and input stalls. cfg_wr_en/cfg_wr_data set the capacity (values above
// the depth act as the depth) and may only be written while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and sets capacity to 16; slot contents are left as they are.
// ----------------------------------------------------------------------------
module compacting_queue_with_removal #(
  parameter int DEPTH       = cq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cq_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cq_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [VALUE_WIDTH-1:0]       in_element,
  input  logic signed [VALUE_WIDTH-1:0]       in_match_key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cq_pkg::STATUS_W-1:0]         out_status,
  output logic signed [VALUE_WIDTH-1:0]       out_value_out,
  output logic [CNT_W-1:0]                    out_length,
  input  logic                                cfg_wr_en,
  input  logic [cq_pkg::CFG_W-1:0]            cfg_wr_data
);

  localparam int CMP_W = (CNT_W > cq_pkg::CFG_W) ? CNT_W : cq_pkg::CFG_W;

  cq_pkg::state_t             state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [cq_pkg::CFG_W-1:0]   cap_r;
  logic [VALUE_WIDTH-1:0]     key_r, key_nxt;
  logic [VALUE_WIDTH-1:0]     head_r, head_nxt;
  logic                       remdeq_r, remdeq_nxt;
  logic                       hit_r, hit_nxt;
  logic                       out_valid_r;
  cq_pkg::status_t            out_status_r;
  logic [VALUE_WIDTH-1:0]     out_value_r;
  logic [CNT_W-1:0]           out_length_r;

  cq_pkg::cell_op_t           cell_op;
  logic [VALUE_WIDTH-1:0]     cell_key;
  logic [VALUE_WIDTH-1:0]     cell_data [DEPTH];
  logic [DEPTH:0]             del_chain;
  logic                       any_match;

  logic                       accept;
  logic                       out_free;
  logic                       empty;
  logic                       full;
  logic                       res_load;
  cq_pkg::status_t            res_status;
  logic [VALUE_WIDTH-1:0]     res_value;
  logic                       start_scan;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != cq_pkg::S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign empty     = count_r == '0;
  assign any_match = del_chain[DEPTH];

  // refused when at the configured capacity or at the physical depth
  assign full = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (CMP_W'(count_r) >= CMP_W'(DEPTH));

  // the match key only matters during the scan
  assign cell_key     = key_r;
  assign del_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_data[g+1];
    end
    cq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .cell_op   (cell_op),
      .count     (count_r),
      .element   (in_element),
      .key       (cell_key),
      .next_data (upper),
      .del_in    (del_chain[g]),
      .data      (cell_data[g]),
      .del_out   (del_chain[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cq_pkg::S_IDLE: begin
        if (start_scan) begin
          state_nxt = cq_pkg::S_SCAN;
        end
      end
      cq_pkg::S_SCAN: begin
        if (!any_match && out_free) begin
          state_nxt = cq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath control and result
  always_comb begin
    cell_op    = cq_pkg::CELL_HOLD;
    count_nxt  = count_r;
    key_nxt    = key_r;
    head_nxt   = head_r;
    remdeq_nxt = remdeq_r;
    hit_nxt    = hit_r;
    res_load   = 1'b0;
    res_status = cq_pkg::ST_OK;
    res_value  = '0;
    start_scan = 1'b0;
    unique case (state_r)
      cq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cq_pkg::op_t'(in_kind))
            cq_pkg::OP_ENQ: begin
              res_load = 1'b1;
              if (full) begin
                res_status = cq_pkg::ST_FULL;
              end else begin
                cell_op   = cq_pkg::CELL_LOAD;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            cq_pkg::OP_DEQ: begin
              res_load = 1'b1;
              if (empty) begin
                res_status = cq_pkg::ST_EMPTY;
              end else begin
                cell_op   = cq_pkg::CELL_SHIFT;
                count_nxt = count_r - CNT_W'(1);
                res_value = cell_data[0];
              end
            end
            cq_pkg::OP_REM: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = cq_pkg::ST_EMPTY;
              end else begin
                start_scan = 1'b1;
                key_nxt    = in_match_key;
                head_nxt   = '0;
                remdeq_nxt = 1'b0;
                hit_nxt    = 1'b0;
              end
            end
            cq_pkg::OP_REMDEQ: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = cq_pkg::ST_EMPTY;
              end else begin
                // pop the head now, scan the remainder afterwards
                cell_op    = cq_pkg::CELL_SHIFT;
                count_nxt  = count_r - CNT_W'(1);
                start_scan = 1'b1;
                key_nxt    = in_match_key;
                head_nxt   = cell_data[0];
                remdeq_nxt = 1'b1;
                hit_nxt    = 1'b0;
              end
            end
            cq_pkg::OP_PEEK: begin
              res_load = 1'b1;
              if (empty) begin
                res_status = cq_pkg::ST_EMPTY;
              end else begin
                res_value = cell_data[0];
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      cq_pkg::S_SCAN: begin
        if (any_match) begin
          cell_op   = cq_pkg::CELL_COMPACT;
          count_nxt = count_r - CNT_W'(1);
          hit_nxt   = 1'b1;
        end else if (out_free) begin
          res_load = 1'b1;
          if (remdeq_r) begin
            res_value = head_r;
          end else if (hit_r) begin
            res_value = key_r;
          end else begin
            res_status = cq_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        cell_op = cq_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cq_pkg::S_IDLE;
      count_r     <= '0;
      cap_r       <= cq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    head_r   <= head_nxt;
    remdeq_r <= remdeq_nxt;
    hit_r    <= hit_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_length_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_length    = out_length_r;

endmodule

@@ tb/cq_result_checker.sv @@
// ----------------------------------------------------------------------------
// cq_result_checker: result checker for the compacting queue
// Watches the input, result and capacity ports, keeps its own copy of the
// queue contents, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module cq_result_checker
  import cq_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [KIND_W-1:0]                   in_kind,
  input  logic signed [VALUE_WIDTH_DEF-1:0]   in_element,
  input  logic signed [VALUE_WIDTH_DEF-1:0]   in_match_key,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [STATUS_W-1:0]                 out_status,
  input  logic signed [VALUE_WIDTH_DEF-1:0]   out_value_out,
  input  logic [$clog2(DEPTH_DEF+1)-1:0]      out_length,
  input  logic                                cfg_wr_en,
  input  logic [CFG_W-1:0]                    cfg_wr_data,
  output int                                  outstanding,
  output int                                  mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W     = VALUE_WIDTH_DEF;
  localparam int LEN_W = $clog2(DEPTH_DEF + 1);

  typedef struct packed {
    status_t               status;
    logic signed [W-1:0]   value;
    logic [LEN_W-1:0]      length;
  } qresult_t;

  logic signed [W-1:0] held_vals [DEPTH_DEF];
  int                  held;
  logic [CFG_W-1:0]    cap_reg;
  qresult_t            pending_results [$];

  // drop all below start and those from start on equal to key, closing up at 0
  function automatic bit strip_matches(input int start, input logic signed [W-1:0] key);
    int dst;
    bit hit;
    dst = 0;
    hit = 1'b0;
    for (int i = start; i < held; i++) begin
      if (held_vals[i] == key) begin
        hit = 1'b1;
      end else begin
        held_vals[dst] = held_vals[i];
        dst++;
      end
    end
    held = dst;
    return hit;
  endfunction

  function automatic qresult_t queue_op_result(input logic [KIND_W-1:0] kind,
                                               input logic signed [W-1:0] elem,
                                               input logic signed [W-1:0] key);
    qresult_t r;
    int lim;
    lim = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
    r.status = ST_OK;
    r.value  = '0;
    case (kind)
      OP_ENQ: begin
        if (held >= lim) begin
          r.status = ST_FULL;
        end else begin
          held_vals[held] = elem;
          held++;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_vals[0];
          for (int i = 1; i < held; i++) held_vals[i-1] = held_vals[i];
          held--;
        end
      end
      OP_REM: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (strip_matches(0, key)) r.value = key;
        else r.status = ST_NOTFOUND;
      end
      OP_REMDEQ: begin
        // head goes regardless of its value, only the rest is matched
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = held_vals[0];
          void'(strip_matches(1, key));
        end
      end
      OP_PEEK: begin
        if (held == 0) r.status = ST_EMPTY;
        else r.value = held_vals[0];
      end
      default: ;
    endcase
    r.length = LEN_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    qresult_t want;
    if (!rst_n) begin
      held = 0;
      cap_reg = CAP_RESET;
      pending_results.delete();
      outstanding = 0;
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d value %0d length %0d",
                 out_status, out_value_out, out_length);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_value_out !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, out_value_out);
            mismatches++;
          end
          if (out_length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_length);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (in_valid && !in_stall)
        pending_results.push_back(queue_op_result(in_kind, in_element, in_match_key));
      outstanding = pending_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for compacting_queue_with_removal
// Directed words for empty, duplicate, not-found and unused operations, then
// random phases at several capacities with bursty input and random stalls.
// ----------------------------------------------------------------------------
module tb;
  import cq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W              = VALUE_WIDTH_DEF;
  localparam int LEN_W          = $clog2(DEPTH_DEF + 1);
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 150;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_LIMIT    = 5000;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [KIND_W-1:0]      in_kind = '0;
  logic signed [W-1:0]    in_element = '0;
  logic signed [W-1:0]    in_match_key = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic signed [W-1:0]    out_value_out;
  logic [LEN_W-1:0]       out_length;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  int  chk_outstanding;
  int  chk_errors;
  logic in_taken = 1'b0;
  int  burst_left = 0;
  bit  pressure_armed = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_count = 0;
  int  idle_cycles = 0;

  always #6 clk = ~clk;

  compacting_queue_with_removal uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_element   (in_element),
    .in_match_key (in_match_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .out_length   (out_length),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  cq_result_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_element   (in_element),
    .in_match_key (in_match_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .out_length   (out_length),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .outstanding  (chk_outstanding),
    .mismatches   (chk_errors)
  );

  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // values drawn mostly from a small set so removes find matches
  function automatic logic signed [W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'sd1;
      5: return 32'sh5a5a_5a5a;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic signed [W-1:0] elem,
                           input logic signed [W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_element   <= elem;
    in_match_key <= key;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic send_random_word(input int enq_pct);
    logic [KIND_W-1:0] kind;
    int pick;
    if ($urandom_range(0, 99) < enq_pct) begin
      kind = OP_ENQ;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 5) kind = OP_DEQ;
      else if (pick < 10) kind = OP_REM;
      else if (pick < 14) kind = OP_REMDEQ;
      else if (pick < 18) kind = OP_PEEK;
      else kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    send_word(kind, draw_value(), draw_value());
  endtask

  // only while nothing is in flight
  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    in_valid <= 1'b0;
    burst_left = 0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin : receiver
    int mode;
    int span;
    int phase_ctr;
    phase_ctr = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk);
        phase_ctr++;
        if (pressure_armed && !pressure_done) begin
          out_stall <= 1'b1;
          hold_count++;
          if (hold_count >= HOLD_CYCLES) pressure_done = 1'b1;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (phase_ctr % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cap;
    int enq_pct;
    int drain;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue on every operation
    send_word(OP_PEEK, '0, '0);
    send_word(OP_DEQ, '0, '0);
    send_word(OP_REM, '0, '0);
    send_word(OP_REMDEQ, '0, '0);
    send_word(OP_ENQ, 32'sh8000_0000, '0);
    send_word(OP_ENQ, 32'sh7fff_ffff, '0);
    send_word(OP_ENQ, -32'sd1, '0);
    send_word(OP_ENQ, 32'sh8000_0000, '0);
    send_word(OP_ENQ, 32'sd0, '0);
    send_word(OP_PEEK, '0, '0);
    // duplicate removal, then a miss
    send_word(OP_REM, '1, 32'sh8000_0000);
    send_word(OP_REM, '0, 32'sd12345);
    send_word(OP_REMDEQ, '0, -32'sd1);
    send_word(OP_ENQ, 32'sd0, '0);
    // head equal to key: head popped, the other copy removed
    send_word(OP_REMDEQ, '0, 32'sd0);
    send_word(KIND_SPARE_FIRST, '1, '1);
    send_word(KIND_SPARE_MID, 32'sh5555_5555, 32'sh5555_5555);
    send_word(KIND_SPARE_LAST, '0, '0);
    send_word(OP_ENQ, 32'sh5555_5555, '0);
    send_word(OP_ENQ, 32'shaaaa_aaaa, '0);
    send_word(OP_DEQ, '0, '0);
    send_word(OP_DEQ, '0, '0);
    send_word(OP_ENQ, 32'sd7, '0);
    send_word(OP_REMDEQ, '0, 32'sd7);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:  begin cap = 5'd16; enq_pct = 55; end
        1:  begin cap = 5'd31; enq_pct = 70; end
        2:  begin cap = 5'd1;  enq_pct = 40; end
        3:  begin cap = 5'd0;  enq_pct = 40; end
        4:  begin cap = 5'd8;  enq_pct = 60; end
        5:  begin cap = 5'd17; enq_pct = 50; end
        6:  begin cap = 5'd3;  enq_pct = 45; end
        8:  begin cap = 5'd16; enq_pct = 35; end
        9:  begin cap = 5'd2;  enq_pct = 50; end
        10: begin cap = 5'd12; enq_pct = 60; end
        default: begin
          cap = CFG_W'($urandom_range(0, 31));
          enq_pct = $urandom_range(30, 70);
        end
      endcase
      set_capacity(cap);
      // queue fills quickly here, so hold the result side off for a while
      if (ph == 1) pressure_armed = 1'b1;
      repeat (PHASE_WORDS) send_random_word(enq_pct);
    end

    in_valid <= 1'b0;
    drain = 0;
    while (chk_outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (chk_outstanding != 0) $error("%0d result words never arrived", chk_outstanding);
    if (chk_errors == 0 && chk_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ compacting_queue_with_removal.f @@
design/cq_pkg.sv
design/cq_cell.sv
design/compacting_queue_with_removal.sv
tb/cq_result_checker.sv
tb/tb.sv
